[src/tce_pkg.sv]
// ============================================================================
// tce_pkg
// Shared types, constants and helpers for the text console engine.
// ============================================================================
package tce_pkg;

    localparam int COLUMNS  = 80;
    localparam int ROWS     = 25;
    localparam int CELLS    = COLUMNS * ROWS;

    localparam int OP_W     = 3;
    localparam int CHAR_W   = 8;
    localparam int COL_W    = 7;
    localparam int ROW_W    = 5;
    localparam int COLOUR_W = 4;
    localparam int CELL_W   = 16;
    localparam int HW_W     = 11;

    localparam int ADDR_W   = $clog2(CELLS);
    localparam int POS_W    = $clog2((2 ** ROW_W) * COLUMNS + (2 ** COL_W));

    localparam logic [CELL_W-1:0]   BLANK_CELL = 16'h0020;

    localparam logic [CHAR_W-1:0]   CH_LF = 8'h0A;
    localparam logic [CHAR_W-1:0]   CH_VT = 8'h0B;
    localparam logic [CHAR_W-1:0]   CH_FF = 8'h0C;
    localparam logic [CHAR_W-1:0]   CH_CR = 8'h0D;

    localparam logic [COLOUR_W-1:0] FG_GREEN = 4'd2;
    localparam logic [COLOUR_W-1:0] FG_RED   = 4'd4;
    localparam logic [COLOUR_W-1:0] FG_WHITE = 4'd15;

    localparam logic [COL_W-1:0]    RESET_COL  = '0;
    localparam logic [ROW_W-1:0]    RESET_ROW  = 5'd3;
    localparam logic [ROW_W-1:0]    RESET_TOP  = 5'd1;

    typedef enum logic [OP_W-1:0] {
        OP_PUT   = 3'd0,
        OP_DEL   = 3'd1,
        OP_SETC  = 3'd2,
        OP_CLEAR = 3'd3,
        OP_READ  = 3'd4
    } opcode_t;

    typedef struct packed {
        logic [OP_W-1:0]     opcode;
        logic [CHAR_W-1:0]   char_code;
        logic [COL_W-1:0]    col;
        logic [ROW_W-1:0]    row;
        logic [COLOUR_W-1:0] colour;
    } in_beat_t;

    typedef struct packed {
        logic [CELL_W-1:0]   cell_data;
        logic [COL_W-1:0]    cursor_col;
        logic [ROW_W-1:0]    cursor_row;
        logic [HW_W-1:0]     hw_cursor_pos;
        logic [COLOUR_W-1:0] fg_color;
    } out_beat_t;

    function automatic logic [POS_W-1:0] cell_pos(input logic [ROW_W-1:0] r,
                                                  input logic [COL_W-1:0] c);
        logic [POS_W-1:0] p;
        p = POS_W'(r) * POS_W'(COLUMNS) + POS_W'(c);
        return p;
    endfunction

endpackage

[src/tce_ram.sv]
// ============================================================================
// tce_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ============================================================================
module tce_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[src/text_console_engine.sv]
// ============================================================================
// text_console_engine
// Text console: 80x25 cell memory with put char, delete, cursor, clear, read.
// ============================================================================
// Usage:
//   Commands arrive on in_valid/in_stall/in_data, one beat each; the engine
//   works on one command at a time and holds in_stall high while busy. Each
//   command yields one beat on out_valid/out_stall/out_data with the cursor,
//   hardware cursor and foreground after the command, and the cell for a read.
//   Set cursor, colour codes, newline, delete at column 0 and unused opcodes
//   go straight to the result; put char and delete first write the cell, and
//   a read first reads it. A scroll (scroll_top_row below 25) adds a copy
//   pass over the moved rows, a flush state and a pass over the bottom row;
//   a screen clear adds a pass over every cell. Both go through the single
//   write port of the cell memory.
//   A stalled result holds in its register while the next command is accepted
//   and worked on; that command waits for the register to free.
//   cfg_we/cfg_data write scroll_top_row; write only while idle.
//   Reset: cursor at column 0 row 3, white foreground, hardware cursor 0,
//   scroll_top_row 1; cell contents are undefined until written.
module text_console_engine (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  tce_pkg::in_beat_t     in_data,
    output logic                  out_valid,
    input  logic                  out_stall,
    output tce_pkg::out_beat_t    out_data,
    input  logic                  cfg_we,
    input  logic [tce_pkg::ROW_W-1:0] cfg_data
);

    typedef enum logic [8:0] {
        ST_IDLE    = 9'b000000001,
        ST_COPY    = 9'b000000010,
        ST_FLUSH   = 9'b000000100,
        ST_BLANK   = 9'b000001000,
        ST_CELL_WR = 9'b000010000,
        ST_CLEAR   = 9'b000100000,
        ST_READ    = 9'b001000000,
        ST_RWAIT   = 9'b010000000,
        ST_DONE    = 9'b100000000
    } state_t;

    localparam logic [tce_pkg::ADDR_W-1:0] LAST_ADDR  = tce_pkg::ADDR_W'(tce_pkg::CELLS - 1);
    localparam logic [tce_pkg::ADDR_W-1:0] BLANK_BASE =
        tce_pkg::ADDR_W'((tce_pkg::ROWS - 1) * tce_pkg::COLUMNS);
    localparam logic [tce_pkg::ADDR_W-1:0] ROW_STEP   = tce_pkg::ADDR_W'(tce_pkg::COLUMNS);

    state_t                              state_reg, state_next;
    logic [tce_pkg::ADDR_W-1:0]          addr_reg, addr_next;
    logic                                copy_v_reg, copy_v_next;
    logic [tce_pkg::ADDR_W-1:0]          copy_addr_reg, copy_addr_next;
    logic                                wr_after_reg, wr_after_next;
    logic [tce_pkg::COL_W-1:0]           cell_col_reg, cell_col_next;
    logic [tce_pkg::CELL_W-1:0]          cell_wdata_reg, cell_wdata_next;
    logic [tce_pkg::CELL_W-1:0]          data_reg, data_next;
    logic [tce_pkg::COL_W-1:0]           col_reg, col_next;
    logic [tce_pkg::ROW_W-1:0]           row_reg, row_next;
    logic [tce_pkg::COLOUR_W-1:0]        fg_reg, fg_next;
    logic [tce_pkg::HW_W-1:0]            hw_reg, hw_next;
    logic [tce_pkg::ROW_W-1:0]           top_reg;
    tce_pkg::in_beat_t                   req_reg, req_next;
    tce_pkg::out_beat_t                  out_reg, out_next;
    logic                                out_valid_reg, out_valid_next;

    logic                                ram_we;
    logic [tce_pkg::ADDR_W-1:0]          ram_waddr;
    logic [tce_pkg::CELL_W-1:0]          ram_wdata;
    logic                                ram_re;
    logic [tce_pkg::ADDR_W-1:0]          ram_raddr;
    logic [tce_pkg::CELL_W-1:0]          ram_rdata;

    logic [tce_pkg::ROW_W-1:0]           top_eff;
    logic                                scroll_skip;
    logic [tce_pkg::POS_W-1:0]           top_pos;
    logic [tce_pkg::POS_W-1:0]           in_pos;
    logic [tce_pkg::POS_W-1:0]           req_pos;
    logic [tce_pkg::POS_W-1:0]           wr_pos;
    logic                                accept;
    logic                                wrap;

    tce_ram #(
        .WIDTH (tce_pkg::CELL_W),
        .DEPTH (tce_pkg::CELLS)
    ) u_cells (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign accept      = in_valid && !in_stall;
    assign in_stall    = (state_reg != ST_IDLE);
    assign out_valid   = out_valid_reg;
    assign out_data    = out_reg;

    assign top_eff     = (top_reg == '0) ? tce_pkg::RESET_TOP : top_reg;
    assign scroll_skip = (top_eff >= tce_pkg::ROWS);
    assign top_pos     = tce_pkg::cell_pos(top_eff, '0);
    assign in_pos      = tce_pkg::cell_pos(in_data.row, in_data.col);
    assign req_pos     = tce_pkg::cell_pos(req_reg.row, req_reg.col);
    assign wr_pos      = tce_pkg::cell_pos(row_reg, cell_col_reg);
    assign wrap        = (col_reg >= tce_pkg::COLUMNS);

    always_comb
    begin
        state_next      = state_reg;
        addr_next       = addr_reg;
        copy_v_next     = 1'b0;
        copy_addr_next  = copy_addr_reg;
        wr_after_next   = wr_after_reg;
        cell_col_next   = cell_col_reg;
        cell_wdata_next = cell_wdata_reg;
        data_next       = data_reg;
        col_next        = col_reg;
        row_next        = row_reg;
        fg_next         = fg_reg;
        hw_next         = hw_reg;
        req_next        = req_reg;
        out_next        = out_reg;
        out_valid_next  = out_valid_reg && out_stall;

        ram_re          = 1'b0;
        ram_raddr       = addr_reg;
        ram_we          = 1'b0;
        ram_waddr       = copy_addr_reg;
        ram_wdata       = ram_rdata;

        // finish the row move: data read last cycle lands one row up
        if (copy_v_reg)
        begin
            ram_we = 1'b1;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    req_next  = in_data;
                    data_next = '0;
                    case (in_data.opcode)
                        tce_pkg::OP_PUT:
                        begin
                            case (in_data.char_code)
                                tce_pkg::CH_LF:
                                begin
                                    col_next      = '0;
                                    wr_after_next = 1'b0;
                                    addr_next     = top_pos[tce_pkg::ADDR_W-1:0];
                                    state_next    = scroll_skip ? ST_DONE : ST_COPY;
                                end
                                tce_pkg::CH_FF:
                                begin
                                    fg_next    = tce_pkg::FG_GREEN;
                                    state_next = ST_DONE;
                                end
                                tce_pkg::CH_CR:
                                begin
                                    fg_next    = tce_pkg::FG_RED;
                                    state_next = ST_DONE;
                                end
                                tce_pkg::CH_VT:
                                begin
                                    fg_next    = tce_pkg::FG_WHITE;
                                    state_next = ST_DONE;
                                end
                                default:
                                begin
                                    wr_after_next   = 1'b1;
                                    cell_wdata_next = {4'h0, fg_reg, in_data.char_code};
                                    if (wrap)
                                    begin
                                        cell_col_next = '0;
                                        col_next      = tce_pkg::COL_W'(1);
                                        addr_next     = top_pos[tce_pkg::ADDR_W-1:0];
                                        state_next    = scroll_skip ? ST_CELL_WR : ST_COPY;
                                    end
                                    else
                                    begin
                                        cell_col_next = col_reg;
                                        col_next      = col_reg + tce_pkg::COL_W'(1);
                                        state_next    = ST_CELL_WR;
                                    end
                                end
                            endcase
                        end
                        tce_pkg::OP_DEL:
                        begin
                            if (col_reg != '0)
                            begin
                                cell_col_next   = col_reg - tce_pkg::COL_W'(1);
                                cell_wdata_next = tce_pkg::BLANK_CELL;
                                col_next        = col_reg - tce_pkg::COL_W'(1);
                                state_next      = ST_CELL_WR;
                            end
                            else
                            begin
                                state_next = ST_DONE;
                            end
                        end
                        tce_pkg::OP_SETC:
                        begin
                            col_next   = in_data.col;
                            row_next   = in_data.row;
                            hw_next    = in_pos[tce_pkg::HW_W-1:0];
                            state_next = ST_DONE;
                        end
                        tce_pkg::OP_CLEAR:
                        begin
                            addr_next  = '0;
                            state_next = ST_CLEAR;
                        end
                        tce_pkg::OP_READ:
                        begin
                            state_next = ST_READ;
                        end
                        default:
                        begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end

            ST_COPY:
            begin
                ram_re         = 1'b1;
                ram_raddr      = addr_reg;
                copy_v_next    = 1'b1;
                copy_addr_next = addr_reg - ROW_STEP;
                if (addr_reg == LAST_ADDR)
                begin
                    state_next = ST_FLUSH;
                end
                else
                begin
                    addr_next = addr_reg + tce_pkg::ADDR_W'(1);
                end
            end

            ST_FLUSH:
            begin
                addr_next  = BLANK_BASE;
                state_next = ST_BLANK;
            end

            ST_BLANK:
            begin
                ram_we    = 1'b1;
                ram_waddr = addr_reg;
                ram_wdata = tce_pkg::BLANK_CELL;
                if (addr_reg == LAST_ADDR)
                begin
                    state_next = wr_after_reg ? ST_CELL_WR : ST_DONE;
                end
                else
                begin
                    addr_next = addr_reg + tce_pkg::ADDR_W'(1);
                end
            end

            ST_CELL_WR:
            begin
                if (cell_col_reg < tce_pkg::COLUMNS && row_reg < tce_pkg::ROWS)
                begin
                    ram_we = 1'b1;
                end
                ram_waddr  = wr_pos[tce_pkg::ADDR_W-1:0];
                ram_wdata  = cell_wdata_reg;
                state_next = ST_DONE;
            end

            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = addr_reg;
                ram_wdata = tce_pkg::BLANK_CELL | {req_reg.colour, 12'h000};
                if (addr_reg == LAST_ADDR)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    addr_next = addr_reg + tce_pkg::ADDR_W'(1);
                end
            end

            ST_READ:
            begin
                ram_raddr = req_pos[tce_pkg::ADDR_W-1:0];
                if (req_reg.col < tce_pkg::COLUMNS && req_reg.row < tce_pkg::ROWS)
                begin
                    ram_re     = 1'b1;
                    state_next = ST_RWAIT;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end

            ST_RWAIT:
            begin
                data_next  = ram_rdata;
                state_next = ST_DONE;
            end

            ST_DONE:
            begin
                // hold until the result register is free
                if (!out_valid_reg || !out_stall)
                begin
                    out_next.cell_data     = data_reg;
                    out_next.cursor_col    = col_reg;
                    out_next.cursor_row    = row_reg;
                    out_next.hw_cursor_pos = hw_reg;
                    out_next.fg_color      = fg_reg;
                    out_valid_next         = 1'b1;
                    state_next             = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            copy_v_reg    <= 1'b0;
            wr_after_reg  <= 1'b0;
            col_reg       <= tce_pkg::RESET_COL;
            row_reg       <= tce_pkg::RESET_ROW;
            fg_reg        <= tce_pkg::FG_WHITE;
            hw_reg        <= '0;
            top_reg       <= tce_pkg::RESET_TOP;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            copy_v_reg    <= copy_v_next;
            wr_after_reg  <= wr_after_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            fg_reg        <= fg_next;
            hw_reg        <= hw_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                top_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg       <= addr_next;
        copy_addr_reg  <= copy_addr_next;
        cell_col_reg   <= cell_col_next;
        cell_wdata_reg <= cell_wdata_next;
        data_reg       <= data_next;
        req_reg        <= req_next;
        out_reg        <= out_next;
    end

endmodule

[verif/tb_text_console_engine.sv]
// ============================================================================
// tb_text_console_engine
// Self-checking testbench for the text console engine.
//
// Shadow copies of the cell memory, cursor, foreground and hardware cursor are
// updated per accepted command, scroll_top_row per cfg write. The expected reply
// beat is queued on acceptance. Each reply beat is checked field by field,
// in order, against that queue. Directed tests cover the reset state, screen
// clear, the colour control codes, margin wrap and newline scrolls, and
// off-screen cursor positions. They also cover the scroll_top_row extremes
// (zero, last row and past it). A random phase follows for each of several
// scroll_top_row settings. Both channels idle at random, with some phases
// running back to back.
// ============================================================================
module tb_text_console_engine;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [tce_pkg::OP_W-1:0] OP_UNUSED_FIRST = 3'd5;
    localparam logic [tce_pkg::OP_W-1:0] OP_UNUSED_LAST  = 3'd7;

    localparam int IN_W         = $bits(tce_pkg::in_beat_t);
    localparam int CYCLE_LIMIT  = 2_000_000;
    localparam int PHASE_ITEMS  = 16;
    localparam int PHASE_COUNT  = 8;
    localparam int DRAIN_CYCLES = 100;
    localparam int MAX_REPORTS  = 40;

    logic                         clk       = 1'b0;
    logic                         rst_n     = 1'b0;
    logic                         in_valid  = 1'b0;
    logic                         in_stall;
    tce_pkg::in_beat_t            in_data   = '0;
    logic                         out_valid;
    logic                         out_stall = 1'b0;
    tce_pkg::out_beat_t           out_data;
    logic                         cfg_we    = 1'b0;
    logic [tce_pkg::ROW_W-1:0]    cfg_data  = '0;

    // shadow console state
    logic [tce_pkg::CELL_W-1:0]   shadow_cells [tce_pkg::CELLS];
    logic [tce_pkg::COL_W-1:0]    cur_col;
    logic [tce_pkg::ROW_W-1:0]    cur_row;
    logic [tce_pkg::COLOUR_W-1:0] cur_fg;
    logic [tce_pkg::HW_W-1:0]     hw_pos;
    logic [tce_pkg::ROW_W-1:0]    top_row;

    tce_pkg::out_beat_t           console_replies [$];
    tce_pkg::out_beat_t           want;

    bit                  quiet       = 1'b0;
    int                  stall_left  = 0;
    int                  cycle_count = 0;
    int                  n_cmds      = 0;
    int                  n_checked   = 0;
    int                  n_reads     = 0;
    int                  n_scrolls   = 0;
    int                  n_cfg       = 0;
    int                  n_errors    = 0;

    text_console_engine dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    function automatic int pick_gap();
        int r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic void store_cell(int c, int r, logic [tce_pkg::CELL_W-1:0] v);
        if (c < tce_pkg::COLUMNS && r < tce_pkg::ROWS)
            shadow_cells[r * tce_pkg::COLUMNS + c] = v;
    endfunction

    function automatic void scroll_up();
        int first;
        first = (top_row == 0) ? 1 : int'(top_row);
        n_scrolls++;
        if (first >= tce_pkg::ROWS)
            return;
        for (int r = first; r < tce_pkg::ROWS; r++)
            for (int c = 0; c < tce_pkg::COLUMNS; c++)
                shadow_cells[(r - 1) * tce_pkg::COLUMNS + c] =
                    shadow_cells[r * tce_pkg::COLUMNS + c];
        for (int c = 0; c < tce_pkg::COLUMNS; c++)
            shadow_cells[(tce_pkg::ROWS - 1) * tce_pkg::COLUMNS + c] = tce_pkg::BLANK_CELL;
    endfunction

    function automatic void put_char(logic [tce_pkg::CHAR_W-1:0] ch);
        case (ch)
            tce_pkg::CH_LF:
            begin
                cur_col = '0;
                scroll_up();
            end
            tce_pkg::CH_FF: cur_fg = tce_pkg::FG_GREEN;
            tce_pkg::CH_CR: cur_fg = tce_pkg::FG_RED;
            tce_pkg::CH_VT: cur_fg = tce_pkg::FG_WHITE;
            default:
            begin
                if (cur_col >= tce_pkg::COLUMNS)
                begin
                    cur_col = '0;
                    scroll_up();
                end
                store_cell(int'(cur_col), int'(cur_row), {4'h0, cur_fg, ch});
                cur_col = cur_col + 1'b1;
            end
        endcase
    endfunction

    function automatic tce_pkg::out_beat_t apply_console_cmd(tce_pkg::in_beat_t b);
        tce_pkg::out_beat_t o;
        o = '0;
        case (b.opcode)
            tce_pkg::OP_PUT: put_char(b.char_code);
            tce_pkg::OP_DEL:
            begin
                if (cur_col != 0)
                begin
                    store_cell(int'(cur_col) - 1, int'(cur_row), tce_pkg::BLANK_CELL);
                    cur_col = cur_col - 1'b1;
                end
            end
            tce_pkg::OP_SETC:
            begin
                cur_col = b.col;
                cur_row = b.row;
                hw_pos  = tce_pkg::HW_W'(int'(b.row) * tce_pkg::COLUMNS + int'(b.col));
            end
            tce_pkg::OP_CLEAR:
            begin
                for (int i = 0; i < tce_pkg::CELLS; i++)
                    shadow_cells[i] = tce_pkg::BLANK_CELL | {b.colour, 12'h000};
            end
            tce_pkg::OP_READ:
            begin
                n_reads++;
                if (b.col < tce_pkg::COLUMNS && b.row < tce_pkg::ROWS)
                    o.cell_data = shadow_cells[int'(b.row) * tce_pkg::COLUMNS + int'(b.col)];
            end
            default: ;
        endcase
        o.cursor_col    = cur_col;
        o.cursor_row    = cur_row;
        o.hw_cursor_pos = hw_pos;
        o.fg_color      = cur_fg;
        return o;
    endfunction

    task automatic issue_cmd(input tce_pkg::in_beat_t b);
        int gap;
        in_valid <= 1'b1;
        in_data  <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        console_replies.push_back(apply_console_cmd(b));
        n_cmds++;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic do_cmd(input logic [tce_pkg::OP_W-1:0] op,
                          input logic [tce_pkg::CHAR_W-1:0] ch,
                          input logic [tce_pkg::COL_W-1:0] c,
                          input logic [tce_pkg::ROW_W-1:0] r,
                          input logic [tce_pkg::COLOUR_W-1:0] bg);
        tce_pkg::in_beat_t b;
        b.opcode    = op;
        b.char_code = ch;
        b.col       = c;
        b.row       = r;
        b.colour    = bg;
        issue_cmd(b);
    endtask

    task automatic wait_idle(input int extra);
        in_valid <= 1'b0;
        while (console_replies.size() != 0)
            @(posedge clk);
        repeat (extra) @(posedge clk);
    endtask

    task automatic set_scroll_top(input logic [tce_pkg::ROW_W-1:0] v);
        wait_idle(4);
        cfg_we   <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        cfg_we   <= 1'b0;
        top_row = v;
        n_cfg++;
    endtask

    task automatic report_field(input string name, input logic [tce_pkg::CELL_W-1:0] exp_v,
                                input logic [tce_pkg::CELL_W-1:0] got_v);
        if (got_v !== exp_v)
        begin
            n_errors++;
            if (n_errors <= MAX_REPORTS)
                $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h",
                         $time, name, exp_v, got_v);
        end
    endtask

    // reply checker and receiver stall
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
            begin
                if (console_replies.size() == 0)
                begin
                    n_errors++;
                    if (n_errors <= MAX_REPORTS)
                        $display("%0t: reply beat with none pending, got 0x%0h",
                                 $time, out_data);
                end
                else
                begin
                    want = console_replies.pop_front();
                    report_field("cell_data", want.cell_data, out_data.cell_data);
                    report_field("cursor_col", tce_pkg::CELL_W'(want.cursor_col),
                                 tce_pkg::CELL_W'(out_data.cursor_col));
                    report_field("cursor_row", tce_pkg::CELL_W'(want.cursor_row),
                                 tce_pkg::CELL_W'(out_data.cursor_row));
                    report_field("hw_cursor_pos", tce_pkg::CELL_W'(want.hw_cursor_pos),
                                 tce_pkg::CELL_W'(out_data.hw_cursor_pos));
                    report_field("fg_color", tce_pkg::CELL_W'(want.fg_color),
                                 tce_pkg::CELL_W'(out_data.fg_color));
                    n_checked++;
                end
            end
            if (stall_left > 0)
            begin
                out_stall <= 1'b1;
                stall_left--;
            end
            else
            begin
                out_stall <= 1'b0;
                stall_left = pick_gap();
            end
        end
    end

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Timeout after %0d cycles, %0d replies pending",
                 cycle_count, console_replies.size());
        $display("Verification failed");
        $finish;
    end

    task automatic test_reset_state();
        do_cmd(OP_UNUSED_LAST, '1, '1, '1, '1);
        do_cmd(tce_pkg::OP_READ, '1, '1, '1, '1);
        do_cmd(tce_pkg::OP_PUT, 8'h58, '0, '0, '0);
        do_cmd(tce_pkg::OP_READ, '0, '0, tce_pkg::RESET_ROW, '0);
    endtask

    task automatic test_clear_screen();
        do_cmd(tce_pkg::OP_CLEAR, '0, '0, '0, 4'hF);
        do_cmd(tce_pkg::OP_READ, '0, tce_pkg::COL_W'(tce_pkg::COLUMNS - 1),
               tce_pkg::ROW_W'(tce_pkg::ROWS - 1), '0);
    endtask

    task automatic test_colour_codes();
        do_cmd(tce_pkg::OP_PUT, tce_pkg::CH_FF, '0, '0, '0);
        do_cmd(tce_pkg::OP_PUT, 8'hFF, '0, '0, '0);
        do_cmd(tce_pkg::OP_PUT, tce_pkg::CH_CR, '0, '0, '0);
        do_cmd(tce_pkg::OP_PUT, 8'h00, '0, '0, '0);
        do_cmd(tce_pkg::OP_PUT, tce_pkg::CH_VT, '0, '0, '0);
        do_cmd(tce_pkg::OP_READ, '0, 7'd1, tce_pkg::RESET_ROW, '0);
        do_cmd(tce_pkg::OP_READ, '0, 7'd2, tce_pkg::RESET_ROW, '0);
    endtask

    task automatic test_wrap_newline();
        do_cmd(tce_pkg::OP_SETC, '0, tce_pkg::COL_W'(tce_pkg::COLUMNS - 1),
               tce_pkg::ROW_W'(tce_pkg::ROWS - 1), '0);
        do_cmd(tce_pkg::OP_PUT, 8'h41, '0, '0, '0);
        do_cmd(tce_pkg::OP_PUT, 8'h42, '0, '0, '0);
        do_cmd(tce_pkg::OP_PUT, tce_pkg::CH_LF, '0, '0, '0);
        do_cmd(tce_pkg::OP_READ, '0, '0, tce_pkg::ROW_W'(tce_pkg::ROWS - 2), '0);
    endtask

    task automatic test_cursor_edges();
        do_cmd(tce_pkg::OP_DEL, '0, '0, '0, '0);
        do_cmd(tce_pkg::OP_SETC, '1, '1, '1, '1);
        do_cmd(tce_pkg::OP_PUT, 8'h7E, '0, '0, '0);
        do_cmd(tce_pkg::OP_DEL, '0, '0, '0, '0);
    endtask

    task automatic test_scroll_top();
        set_scroll_top('0);
        do_cmd(tce_pkg::OP_PUT, tce_pkg::CH_LF, '0, '0, '0);
        set_scroll_top(tce_pkg::ROW_W'(tce_pkg::ROWS - 1));
        do_cmd(tce_pkg::OP_PUT, tce_pkg::CH_LF, '0, '0, '0);
        do_cmd(tce_pkg::OP_READ, '0, tce_pkg::COL_W'(tce_pkg::COLUMNS - 1),
               tce_pkg::ROW_W'(tce_pkg::ROWS - 2), '0);
        set_scroll_top('1);
        do_cmd(tce_pkg::OP_PUT, tce_pkg::CH_LF, '0, '0, '0);
        set_scroll_top(tce_pkg::RESET_TOP);
    endtask

    task automatic random_cmd();
        tce_pkg::in_beat_t b;
        int                pick;
        int                sub;
        b    = tce_pkg::in_beat_t'(IN_W'($urandom));
        pick = $urandom_range(0, 99);
        sub  = $urandom_range(0, 99);
        if (pick < 45)
        begin
            b.opcode = tce_pkg::OP_PUT;
            if (sub < 12)
                b.char_code = tce_pkg::CH_LF;
            else if (sub < 16)
                b.char_code = tce_pkg::CH_FF;
            else if (sub < 20)
                b.char_code = tce_pkg::CH_CR;
            else if (sub < 24)
                b.char_code = tce_pkg::CH_VT;
        end
        else if (pick < 53)
            b.opcode = tce_pkg::OP_DEL;
        else if (pick < 66)
        begin
            b.opcode = tce_pkg::OP_SETC;
            if (sub < 85)
                b.row = tce_pkg::ROW_W'($urandom_range(0, tce_pkg::ROWS - 1));
            if (sub < 60)
                b.col = tce_pkg::COL_W'($urandom_range(0, tce_pkg::COLUMNS - 1));
            else if (sub < 85)
                b.col = tce_pkg::COL_W'($urandom_range(tce_pkg::COLUMNS - 6,
                                                       tce_pkg::COLUMNS));
        end
        else if (pick < 69)
            b.opcode = tce_pkg::OP_CLEAR;
        else if (pick < 95)
        begin
            // aim nearly half the reads at the cursor line or the line above it, where writes and scrolls land
            b.opcode = tce_pkg::OP_READ;
            if (sub < 85)
                b.col = tce_pkg::COL_W'($urandom_range(0, tce_pkg::COLUMNS - 1));
            if (sub < 45 && cur_row < tce_pkg::ROWS)
                b.row = ($urandom_range(0, 1) && cur_row != 0) ? cur_row - 1'b1 : cur_row;
            else if (sub < 85)
                b.row = tce_pkg::ROW_W'($urandom_range(0, tce_pkg::ROWS - 1));
        end
        else
            b.opcode = tce_pkg::OP_W'($urandom_range(OP_UNUSED_FIRST, OP_UNUSED_LAST));
        issue_cmd(b);
    endtask

    task automatic test_random_traffic();
        logic [tce_pkg::ROW_W-1:0] v;
        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            case (p)
                0:       v = tce_pkg::RESET_TOP;
                1:       v = tce_pkg::ROW_W'(tce_pkg::ROWS - 1);
                2:       v = tce_pkg::ROW_W'($urandom_range(2, tce_pkg::ROWS - 2));
                3:       v = tce_pkg::ROW_W'(tce_pkg::ROWS);
                4:       v = '0;
                5:       v = '1;
                6:       v = tce_pkg::ROW_W'($urandom_range(1, tce_pkg::ROWS - 1));
                default: v = tce_pkg::RESET_TOP;
            endcase
            set_scroll_top(v);
            quiet = (p == 2 || p == 6);
            repeat (PHASE_ITEMS) random_cmd();
        end
        quiet = 1'b0;
    endtask

    initial
    begin
        cur_col = tce_pkg::RESET_COL;
        cur_row = tce_pkg::RESET_ROW;
        cur_fg  = tce_pkg::FG_WHITE;
        hw_pos  = '0;
        top_row = tce_pkg::RESET_TOP;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_state();
        test_clear_screen();
        test_colour_codes();
        test_wrap_newline();
        test_cursor_edges();
        test_scroll_top();
        test_random_traffic();

        wait_idle(DRAIN_CYCLES);

        $display("Ran %0d commands over %0d scroll_top_row settings; %0d replies checked",
                 n_cmds, n_cfg, n_checked);
        $display("Covered %0d cell reads and %0d scroll requests in %0d cycles",
                 n_reads, n_scrolls, cycle_count);
        if (n_errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

[sim.f]
src/tce_pkg.sv
src/tce_ram.sv
src/text_console_engine.sv
verif/tb_text_console_engine.sv
